FILE: src/oriented_box_overlap_core_defines.svh
// ----------------------------------------------------------------------------
// Oriented box overlap core: assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_OVERLAP_CORE_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OBO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OBO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/obo_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box overlap package
// Widths, beat types, reject codes and the sine table shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obo_pkg;

  localparam int COORD_BITS = 16;
  localparam int TRIG_BITS  = 15;
  localparam int ANGLE_BITS = 9;
  localparam int STAGE_BITS = 4;

  localparam int SIZE_BITS = COORD_BITS - 1;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int TRIG_FRAC = TRIG_BITS - 1;
  // Signed trig width; one extra bit so that exactly +1.0 and -1.0 fit.
  localparam int TRIG_W    = TRIG_BITS + 1;

  // Axis-test widths.
  localparam int EXT_W  = SIZE_BITS + TRIG_W + 1;
  localparam int PROJ_W = EXT_W + TRIG_W;
  localparam int DOT_W  = DIFF_BITS + TRIG_W + 1;
  localparam int CMP_W  = PROJ_W + TRIG_W;

  // Bounding-circle widths.
  localparam int SQ_D_W = 2 * DIFF_BITS;
  localparam int SQ_S_W = 2 * SIZE_BITS;
  localparam int P_W    = SQ_D_W + 3;
  localparam int Q_W    = SQ_S_W + 1;
  localparam int L_W    = P_W + 1;
  localparam int LB_W   = Q_W + 1;

  localparam int QUARTER   = 90;
  localparam int HALF      = 180;
  localparam int THREE_Q   = 270;
  localparam int FULL      = 360;
  localparam int QIDX_BITS = $clog2(QUARTER + 1);

  localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;
  localparam int TAYLOR_TERMS = 8;

  localparam logic [STAGE_BITS-1:0] REJ_NONE    = STAGE_BITS'(0);
  localparam logic [STAGE_BITS-1:0] REJ_CIRCLE  = STAGE_BITS'(1);
  localparam logic [STAGE_BITS-1:0] REJ_A_EDGE0 = STAGE_BITS'(2);
  localparam logic [STAGE_BITS-1:0] REJ_A_EDGE1 = STAGE_BITS'(3);
  localparam logic [STAGE_BITS-1:0] REJ_B_EDGE0 = STAGE_BITS'(6);
  localparam logic [STAGE_BITS-1:0] REJ_B_EDGE1 = STAGE_BITS'(7);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_center_x;
    logic signed [COORD_BITS-1:0] a_center_y;
    logic [SIZE_BITS-1:0]         a_width;
    logic [SIZE_BITS-1:0]         a_height;
    logic [ANGLE_BITS-1:0]        a_angle;
    logic signed [COORD_BITS-1:0] b_center_x;
    logic signed [COORD_BITS-1:0] b_center_y;
    logic [SIZE_BITS-1:0]         b_width;
    logic [SIZE_BITS-1:0]         b_height;
    logic [ANGLE_BITS-1:0]        b_angle;
  } item_t;

  typedef struct packed {
    logic                  overlap;
    logic [STAGE_BITS-1:0] reject_stage;
  } result_t;

  // Orientation and size of one box as seen by an axis unit.
  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    logic [SIZE_BITS-1:0]     w;
    logic [SIZE_BITS-1:0]     h;
  } box_geom_t;

  typedef logic [TRIG_BITS-1:0] sine_table_t [0:QUARTER];

  // Unsigned quotient by shift and subtract, evaluated at elaboration only.
  function automatic longint unsigned div_u64(longint unsigned num,
                                              longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q30 Taylor series of sin(deg), evaluated at elaboration only.
  function automatic longint unsigned sine_q30(int unsigned deg);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = longint'(deg) * RAD_PER_DEG_Q30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = div_u64(term, longint'((2 * k) * (2 * k + 1)));
      if ((k & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t      tbl;
    longint unsigned  q;
    for (int d = 0; d <= QUARTER; d++) begin
      q = (sine_q30(d) + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
      tbl[d] = TRIG_BITS'(q);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

  // Signed sine of an angle already reduced to 0..359 degrees.
  function automatic logic signed [TRIG_W-1:0] sine_of(logic [ANGLE_BITS-1:0] d);
    logic [ANGLE_BITS-1:0]    r;
    logic                     neg;
    logic signed [TRIG_W-1:0] mag;
    if (d <= ANGLE_BITS'(QUARTER)) begin
      r   = d;
      neg = 1'b0;
    end else if (d <= ANGLE_BITS'(HALF)) begin
      r   = ANGLE_BITS'(HALF) - d;
      neg = 1'b0;
    end else if (d <= ANGLE_BITS'(THREE_Q)) begin
      r   = d - ANGLE_BITS'(HALF);
      neg = 1'b1;
    end else begin
      r   = ANGLE_BITS'(FULL) - d;
      neg = 1'b1;
    end
    mag = $signed(TRIG_W'(SINE_TABLE[r[QIDX_BITS-1:0]]));
    return neg ? -mag : mag;
  endfunction

endpackage

`default_nettype wire

FILE: src/obo_trig.sv
// ----------------------------------------------------------------------------
// Oriented box overlap: sine and cosine lookup
// Reduces a degree angle and returns registered Q1.14 sine and cosine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obo_trig
  import obo_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [ANGLE_BITS-1:0]    angle,
  output logic signed [TRIG_W-1:0]      sin_q,
  output logic signed [TRIG_W-1:0]      cos_q
);

  logic [ANGLE_BITS-1:0] deg;
  logic [ANGLE_BITS-1:0] deg_shift;
  logic [ANGLE_BITS-1:0] deg_cos;

  // Cosine is the sine of the angle advanced by a quarter turn.
  always_comb begin
    deg       = (angle >= ANGLE_BITS'(FULL)) ? angle - ANGLE_BITS'(FULL) : angle;
    deg_shift = deg + ANGLE_BITS'(QUARTER);
    deg_cos   = (deg_shift >= ANGLE_BITS'(FULL)) ? deg_shift - ANGLE_BITS'(FULL)
                                                 : deg_shift;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= sine_of(deg);
      cos_q <= sine_of(deg_cos);
    end
  end

endmodule

`default_nettype wire

FILE: src/obo_circle.sv
// ----------------------------------------------------------------------------
// Oriented box overlap: bounding-circle test
// Four-stage exact test of 2*dist >= diagA + diagB using squares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obo_circle
  import obo_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [DIFF_BITS-1:0] dx,
  input  wire logic signed [DIFF_BITS-1:0] dy,
  input  wire logic [SIZE_BITS-1:0]        a_w,
  input  wire logic [SIZE_BITS-1:0]        a_h,
  input  wire logic [SIZE_BITS-1:0]        b_w,
  input  wire logic [SIZE_BITS-1:0]        b_h,
  output logic                             apart
);

  logic signed [SQ_D_W-1:0] dx2;
  logic signed [SQ_D_W-1:0] dy2;
  logic [SQ_S_W-1:0]        aw2, ah2, bw2, bh2;
  logic signed [L_W-1:0]    diff;
  logic [Q_W-1:0]           qa, qb;
  logic                     diff_neg, diff_big;
  logic [2*LB_W-1:0]        diff_sq;
  logic [2*Q_W-1:0]         qprod;

  always_ff @(posedge clk) begin
    if (en) begin
      // Squares of the center offset and of the sizes.
      dx2 <= SQ_D_W'(dx) * SQ_D_W'(dx);
      dy2 <= SQ_D_W'(dy) * SQ_D_W'(dy);
      aw2 <= SQ_S_W'(a_w) * SQ_S_W'(a_w);
      ah2 <= SQ_S_W'(a_h) * SQ_S_W'(a_h);
      bw2 <= SQ_S_W'(b_w) * SQ_S_W'(b_w);
      bh2 <= SQ_S_W'(b_h) * SQ_S_W'(b_h);
      // l = 4*dist^2 - qa - qb.
      qa   <= Q_W'(aw2) + Q_W'(ah2);
      qb   <= Q_W'(bw2) + Q_W'(bh2);
      diff <= ((L_W'(dx2) + L_W'(dy2)) <<< 2) - L_W'(Q_W'(aw2) + Q_W'(ah2))
              - L_W'(Q_W'(bw2) + Q_W'(bh2));
      // Apart when l >= 0 and l^2 >= 4*qa*qb.
      diff_neg <= diff < 0;
      diff_big <= (diff >>> LB_W) != '0;
      diff_sq  <= (2*LB_W)'(diff[LB_W-1:0]) * (2*LB_W)'(diff[LB_W-1:0]);
      qprod    <= (2*Q_W)'(qa) * (2*Q_W)'(qb);
      apart    <= !diff_neg && (diff_big || (diff_sq >= {qprod, 2'b00}));
    end
  end

endmodule

`default_nettype wire

FILE: src/obo_axis.sv
// ----------------------------------------------------------------------------
// Oriented box overlap: one separating-axis unit
// Four-stage test of |center gap| > radius A + radius B along one axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obo_axis
  import obo_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire box_geom_t                   box_a,
  input  wire box_geom_t                   box_b,
  input  wire logic signed [DIFF_BITS-1:0] dx,
  input  wire logic signed [DIFF_BITS-1:0] dy,
  input  wire logic signed [TRIG_W-1:0]    axis_x,
  input  wire logic signed [TRIG_W-1:0]    axis_y,
  input  wire logic                        degenerate,
  output logic                             separated
);

  // Stage 1: box edge vectors and the center-offset products.
  logic signed [EXT_W-1:0]  wc_a, ws_a, hs_a, hc_a, wc_b, ws_b, hs_b, hc_b;
  logic signed [DOT_W-1:0]  dxp, dyp;
  logic signed [TRIG_W-1:0] ax1, ay1;
  logic [2:0]               degen_pipe;
  // Stage 2: projections of the edge vectors onto the axis.
  logic signed [PROJ_W-1:0] pa1, pa2, pa3, pa4, pb1, pb2, pb3, pb4;
  logic signed [DOT_W-1:0]  dot;
  // Stage 3: radii and center gap magnitude.
  logic [CMP_W-1:0]         ra1, ra2, rb1, rb2, gap;
  logic signed [CMP_W-1:0]  sa1, sa2, sb1, sb2;

  always_comb begin
    sa1 = CMP_W'(pa1) + CMP_W'(pa2);
    sa2 = CMP_W'(pa4) - CMP_W'(pa3);
    sb1 = CMP_W'(pb1) + CMP_W'(pb2);
    sb2 = CMP_W'(pb4) - CMP_W'(pb3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wc_a <= EXT_W'($signed({1'b0, box_a.w})) * EXT_W'(box_a.c);
      ws_a <= EXT_W'($signed({1'b0, box_a.w})) * EXT_W'(box_a.s);
      hs_a <= EXT_W'($signed({1'b0, box_a.h})) * EXT_W'(box_a.s);
      hc_a <= EXT_W'($signed({1'b0, box_a.h})) * EXT_W'(box_a.c);
      wc_b <= EXT_W'($signed({1'b0, box_b.w})) * EXT_W'(box_b.c);
      ws_b <= EXT_W'($signed({1'b0, box_b.w})) * EXT_W'(box_b.s);
      hs_b <= EXT_W'($signed({1'b0, box_b.h})) * EXT_W'(box_b.s);
      hc_b <= EXT_W'($signed({1'b0, box_b.h})) * EXT_W'(box_b.c);
      dxp  <= DOT_W'(dx) * DOT_W'(axis_x);
      dyp  <= DOT_W'(dy) * DOT_W'(axis_y);
      ax1  <= axis_x;
      ay1  <= axis_y;
      degen_pipe <= {degen_pipe[1:0], degenerate};

      pa1 <= PROJ_W'(wc_a) * PROJ_W'(ax1);
      pa2 <= PROJ_W'(ws_a) * PROJ_W'(ay1);
      pa3 <= PROJ_W'(hs_a) * PROJ_W'(ax1);
      pa4 <= PROJ_W'(hc_a) * PROJ_W'(ay1);
      pb1 <= PROJ_W'(wc_b) * PROJ_W'(ax1);
      pb2 <= PROJ_W'(ws_b) * PROJ_W'(ay1);
      pb3 <= PROJ_W'(hs_b) * PROJ_W'(ax1);
      pb4 <= PROJ_W'(hc_b) * PROJ_W'(ay1);
      dot <= dxp + dyp;

      ra1 <= sa1[CMP_W-1] ? -sa1 : sa1;
      ra2 <= sa2[CMP_W-1] ? -sa2 : sa2;
      rb1 <= sb1[CMP_W-1] ? -sb1 : sb1;
      rb2 <= sb2[CMP_W-1] ? -sb2 : sb2;
      // Corners carry the center at twice the trig scale.
      gap <= CMP_W'(dot[DOT_W-1] ? -dot : dot) << (TRIG_FRAC + 1);

      separated <= !degen_pipe[2] && (gap > ra1 + ra2 + rb1 + rb2);
    end
  end

endmodule

`default_nettype wire

FILE: src/oriented_box_overlap_core.sv
// Oriented box overlap core. Each input beat carries two rotated rectangles
// and produces exactly one result beat saying whether they overlap (touching
// counts as overlap, save that bounding circles that only touch count as
// apart) and, if not, which test first proved them apart: 1 for the bounding
// circles, 2 or 3 for the normals of A's edges, 6 or 7 for the normals of B's
// edges (opposite edges share a normal, so 4, 5, 8 and 9 never appear). The
// core is a six-stage pipeline that accepts one beat every clock unless the
// result side stalls; the whole pipeline advances together, so a stall there
// freezes every stage and item_ready drops in the same cycle as the stall.
// ----------------------------------------------------------------------------
// Oriented box overlap core
// Pipelined separating-axis overlap test for two rotated rectangles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oriented_box_overlap_core
  import obo_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  // Stages one through five before the output register.
  localparam int PIPE_DEPTH = 5;

  logic                        advance;
  logic [PIPE_DEPTH-1:0]       valid_pipe;

  // Stage one registers: center offset and sizes; trig comes from obo_trig.
  logic signed [DIFF_BITS-1:0] dx, dy;
  logic [SIZE_BITS-1:0]        a_w, a_h, b_w, b_h;
  logic signed [TRIG_W-1:0]    a_sin, a_cos, b_sin, b_cos;

  box_geom_t                   geom_a, geom_b;
  logic                        circle_apart;
  logic [3:0]                  axis_sep;
  logic [STAGE_BITS-1:0]       stage_code;

  // The output register is the only place a finished beat can wait, so the
  // pipeline moves whenever that register is empty or being drained.
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe   <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      valid_pipe   <= {valid_pipe[PIPE_DEPTH-2:0], item_valid};
      result_valid <= valid_pipe[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx  <= DIFF_BITS'(item.a_center_x) - DIFF_BITS'(item.b_center_x);
      dy  <= DIFF_BITS'(item.a_center_y) - DIFF_BITS'(item.b_center_y);
      a_w <= item.a_width;
      a_h <= item.a_height;
      b_w <= item.b_width;
      b_h <= item.b_height;
    end
  end

  obo_trig u_trig_a (
    .clk   (clk),
    .en    (advance),
    .angle (item.a_angle),
    .sin_q (a_sin),
    .cos_q (a_cos)
  );

  obo_trig u_trig_b (
    .clk   (clk),
    .en    (advance),
    .angle (item.b_angle),
    .sin_q (b_sin),
    .cos_q (b_cos)
  );

  always_comb begin
    geom_a = '{c: a_cos, s: a_sin, w: a_w, h: a_h};
    geom_b = '{c: b_cos, s: b_sin, w: b_w, h: b_h};
  end

  obo_circle u_circle (
    .clk   (clk),
    .en    (advance),
    .dx    (dx),
    .dy    (dy),
    .a_w   (a_w),
    .a_h   (a_h),
    .b_w   (b_w),
    .b_h   (b_h),
    .apart (circle_apart)
  );

  // Edge normals: (c, s) for the side edges, whose axis is void when the height
  // is zero, and (-s, c) for the bottom and top edges, void at zero width.
  obo_axis u_axis_a0 (
    .clk (clk), .en (advance), .box_a (geom_a), .box_b (geom_b),
    .dx (dx), .dy (dy), .axis_x (a_cos), .axis_y (a_sin),
    .degenerate (a_h == '0), .separated (axis_sep[0])
  );

  obo_axis u_axis_a1 (
    .clk (clk), .en (advance), .box_a (geom_a), .box_b (geom_b),
    .dx (dx), .dy (dy), .axis_x (-a_sin), .axis_y (a_cos),
    .degenerate (a_w == '0), .separated (axis_sep[1])
  );

  obo_axis u_axis_b0 (
    .clk (clk), .en (advance), .box_a (geom_a), .box_b (geom_b),
    .dx (dx), .dy (dy), .axis_x (b_cos), .axis_y (b_sin),
    .degenerate (b_h == '0), .separated (axis_sep[2])
  );

  obo_axis u_axis_b1 (
    .clk (clk), .en (advance), .box_a (geom_a), .box_b (geom_b),
    .dx (dx), .dy (dy), .axis_x (-b_sin), .axis_y (b_cos),
    .degenerate (b_w == '0), .separated (axis_sep[3])
  );

  // The circle test wins over every axis, then the axes in A-then-B order.
  always_comb begin
    priority if (circle_apart) stage_code = REJ_CIRCLE;
    else if (axis_sep[0])      stage_code = REJ_A_EDGE0;
    else if (axis_sep[1])      stage_code = REJ_A_EDGE1;
    else if (axis_sep[2])      stage_code = REJ_B_EDGE0;
    else if (axis_sep[3])      stage_code = REJ_B_EDGE1;
    else                       stage_code = REJ_NONE;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.overlap      <= (stage_code == REJ_NONE);
      result.reject_stage <= stage_code;
    end
  end

endmodule

`default_nettype wire

FILE: src/obo_checker.sv
// ----------------------------------------------------------------------------
// Oriented box overlap: port checker
// Watches the core's ports for stall and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "oriented_box_overlap_core_defines.svh"

module obo_checker
  import obo_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_ready,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  `OBO_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")
  `OBO_ASSERT_NOW(a_stall_blocks_input, clk, rst, result_valid && !result_ready, !item_ready, "input taken while the output is stalled")
  `OBO_ASSERT_NOW(a_overlap_code, clk, rst, result_valid, result.overlap == (result.reject_stage == REJ_NONE), "overlap flag disagrees with reject code")
  `OBO_ASSERT_NOW(a_code_known, clk, rst, result_valid, (result.reject_stage == REJ_NONE) || (result.reject_stage == REJ_CIRCLE) || (result.reject_stage == REJ_A_EDGE0) || (result.reject_stage == REJ_A_EDGE1) || (result.reject_stage == REJ_B_EDGE0) || (result.reject_stage == REJ_B_EDGE1), "reject code outside the reachable set")

endmodule

bind oriented_box_overlap_core obo_checker u_checker (.*);

`default_nettype wire
